FILE: rtl/l2ehp_pkg.sv
package l2ehp_pkg;

    // Frame limits
    localparam int unsigned MAX_FRAME_BYTES = 16384;
    localparam int unsigned PREFIX_BYTES    = 16;
    localparam int unsigned ETH_HDR_BYTES   = 14;

    // Byte queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Ethertypes and PPP protocol numbers
    localparam logic [15:0] ETYPE_VLAN_Q  = 16'h8100;
    localparam logic [15:0] ETYPE_VLAN_AD = 16'h9100;
    localparam logic [15:0] ETYPE_PPPOE   = 16'h8864;
    localparam logic [15:0] ETYPE_MPLS    = 16'h8847;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86dd;
    localparam logic [15:0] ETYPE_ARP     = 16'h0806;
    localparam logic [15:0] ETYPE_RARP    = 16'h8035;
    localparam logic [15:0] ETYPE_PREFIX  = 16'h8903;
    localparam logic [15:0] PPP_IPV4      = 16'h0021;
    localparam logic [15:0] PPP_IPV6      = 16'h0057;
    localparam logic [11:0] VLAN_ID_MASK  = 12'hfff;

    // Result status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_TRUNC_PREFIX  = 3'd1;
    localparam logic [2:0] ST_TRUNC_LINK    = 3'd2;
    localparam logic [2:0] ST_PPPOE_NON_IP  = 3'd3;
    localparam logic [2:0] ST_ETH_NON_IP    = 3'd4;
    localparam logic [2:0] ST_MPLS_NO_IP    = 3'd5;

    // Layer-3 kinds
    localparam logic [1:0] L3_NONE = 2'd0;
    localparam logic [1:0] L3_IPV4 = 2'd1;
    localparam logic [1:0] L3_IPV6 = 2'd2;
    localparam logic [1:0] L3_ARP  = 2'd3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [14:0] frame_length;
        logic        last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  l3_kind;
        logic [15:0] ether_type;
        logic [15:0] next_protocol;
        logic [11:0] outer_vlan;
        logic [11:0] inner_vid;
        logic        outer_vlan_seen;
        logic        inner_vlan_seen;
        logic        mpls_seen;
        logic [4:0]  l2_offset;
        logic [14:0] l3_offset;
    } result_item_t;

    // One classified byte, as handed from front to back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [14:0] pos;
        logic [14:0] length;
        logic        first;
        logic        last;
    } byte_event_t;

endpackage

FILE: rtl/l2ehp_front.sv
module l2ehp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  l2ehp_pkg::byte_item_t byte_data,
    output logic                  ev_valid,
    input  logic                  ev_ready,
    output l2ehp_pkg::byte_event_t ev_data
);
    import l2ehp_pkg::*;

    localparam logic [14:0] POS_MAX = '1;
    localparam logic [14:0] LEN_MAX = 15'(MAX_FRAME_BYTES);

    logic [14:0] pos_reg, pos_next;
    logic        first_reg, first_next;
    logic        take;

    assign byte_ready = ev_ready;
    assign ev_valid   = byte_valid;
    assign take       = byte_valid && ev_ready;

    always_comb
    begin
        ev_data.data_byte = byte_data.data_byte;
        ev_data.pos       = pos_reg;
        ev_data.length    = (byte_data.frame_length > LEN_MAX) ? LEN_MAX
                                                               : byte_data.frame_length;
        ev_data.first     = first_reg;
        ev_data.last      = byte_data.last_byte;
    end

    // Track frame boundary and saturating byte position
    always_comb
    begin
        pos_next   = pos_reg;
        first_next = first_reg;
        if (take)
        begin
            if (byte_data.last_byte)
            begin
                pos_next   = '0;
                first_next = 1'b1;
            end
            else
            begin
                first_next = 1'b0;
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + 15'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
        end
    end

endmodule

FILE: rtl/l2ehp_queue.sv
module l2ehp_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  l2ehp_pkg::byte_event_t push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output l2ehp_pkg::byte_event_t pop_data
);
    import l2ehp_pkg::*;

    localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW+1)'(QUEUE_DEPTH);

    byte_event_t         mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/l2ehp_back.sv
module l2ehp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ev_valid,
    output logic                    ev_ready,
    input  l2ehp_pkg::byte_event_t  ev_data,
    output logic                    res_valid,
    input  logic                    res_ready,
    output l2ehp_pkg::result_item_t res_data
);
    import l2ehp_pkg::*;

    localparam logic [2:0] PH_ETH0  = 3'd0;
    localparam logic [2:0] PH_ETH1  = 3'd1;
    localparam logic [2:0] PH_VLAN  = 3'd2;
    localparam logic [2:0] PH_PPPOE = 3'd3;
    localparam logic [2:0] PH_MPLS  = 3'd4;
    localparam logic [2:0] PH_IPV   = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    localparam logic [15:0] PREFIX_LIMIT = 16'(PREFIX_BYTES + ETH_HDR_BYTES);

    logic [2:0]   phase_reg, phase_next;
    logic [14:0]  hs_reg, hs_next;
    logic [15:0]  recent_reg, recent_next;
    logic [14:0]  len_reg, len_next;
    logic [15:0]  proto_reg, proto_next;
    logic [15:0]  etype_reg, etype_next;
    logic [11:0]  ovlan_reg, ovlan_next;
    logic [11:0]  ivlan_reg, ivlan_next;
    logic [1:0]   vflags_reg, vflags_next;
    logic         mpls_reg, mpls_next;
    logic         prefix_reg, prefix_next;
    logic         sent_reg, sent_next;
    logic         res_valid_reg, res_valid_next;
    result_item_t res_data_reg, res_data_next;

    logic         fire;
    logic         emit;
    logic [2:0]   em_status;
    logic [1:0]   em_kind;
    logic [15:0]  em_proto;
    logic [14:0]  em_off;
    logic         disp;
    logic [15:0]  disp_proto;
    logic [14:0]  disp_off;
    logic [14:0]  rel;
    logic [14:0]  mpls_off;
    logic [15:0]  len_ext;

    assign ev_ready  = !res_valid_reg || res_ready;
    assign fire      = ev_valid && ev_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        hs_next     = hs_reg;
        recent_next = recent_reg;
        len_next    = len_reg;
        proto_next  = proto_reg;
        etype_next  = etype_reg;
        ovlan_next  = ovlan_reg;
        ivlan_next  = ivlan_reg;
        vflags_next = vflags_reg;
        mpls_next   = mpls_reg;
        prefix_next = prefix_reg;
        sent_next   = sent_reg;
        emit        = 1'b0;
        em_status   = ST_OK;
        em_kind     = L3_NONE;
        em_proto    = '0;
        em_off      = '0;
        disp        = 1'b0;
        disp_proto  = '0;
        disp_off    = '0;
        mpls_off    = '0;

        // Start of frame: clear per-frame state, drop runt frames at once
        if (ev_data.first)
        begin
            phase_next  = PH_ETH0;
            hs_next     = '0;
            recent_next = '0;
            len_next    = ev_data.length;
            proto_next  = '0;
            etype_next  = '0;
            ovlan_next  = '0;
            ivlan_next  = '0;
            vflags_next = '0;
            mpls_next   = 1'b0;
            prefix_next = 1'b0;
            sent_next   = 1'b0;
            if (ev_data.length < 15'(ETH_HDR_BYTES))
            begin
                emit       = 1'b1;
                em_status  = ST_TRUNC_LINK;
                phase_next = PH_DONE;
            end
        end

        len_ext = {1'b0, len_next};
        rel     = ev_data.pos - hs_next;

        if (phase_next != PH_DONE)
        begin
            recent_next = {recent_next[7:0], ev_data.data_byte};
            unique case (phase_next)
                PH_ETH0:
                begin
                    if (rel == 15'd13)
                    begin
                        etype_next = recent_next;
                        if (recent_next == ETYPE_PREFIX)
                        begin
                            if (PREFIX_LIMIT >= len_ext)
                            begin
                                emit       = 1'b1;
                                em_status  = ST_TRUNC_PREFIX;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                prefix_next = 1'b1;
                                hs_next     = 15'(PREFIX_BYTES);
                                phase_next  = PH_ETH1;
                            end
                        end
                        else
                        begin
                            disp       = 1'b1;
                            disp_proto = recent_next;
                            disp_off   = 15'(ETH_HDR_BYTES);
                        end
                    end
                end
                PH_ETH1:
                begin
                    if (rel == 15'd13)
                    begin
                        etype_next = recent_next;
                        disp       = 1'b1;
                        disp_proto = recent_next;
                        disp_off   = hs_next + 15'(ETH_HDR_BYTES);
                    end
                end
                PH_VLAN:
                begin
                    if (rel == 15'd1)
                    begin
                        if (vflags_next[0])
                        begin
                            ivlan_next     = recent_next[11:0] & VLAN_ID_MASK;
                            vflags_next[1] = 1'b1;
                        end
                        else
                        begin
                            ovlan_next     = recent_next[11:0] & VLAN_ID_MASK;
                            vflags_next[0] = 1'b1;
                        end
                    end
                    else if (rel == 15'd3)
                    begin
                        etype_next = recent_next;
                        disp       = 1'b1;
                        disp_proto = recent_next;
                        disp_off   = hs_next + 15'd4;
                    end
                end
                PH_PPPOE:
                begin
                    if (rel == 15'd7)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_DONE;
                        if (recent_next == PPP_IPV4 || recent_next == PPP_IPV6)
                        begin
                            em_kind  = (recent_next == PPP_IPV4) ? L3_IPV4 : L3_IPV6;
                            em_proto = recent_next;
                            em_off   = hs_next + 15'd8;
                        end
                        else
                        begin
                            em_status = ST_PPPOE_NON_IP;
                        end
                    end
                end
                PH_MPLS:
                begin
                    if (rel == 15'd3)
                    begin
                        mpls_off = hs_next + 15'd4;
                        hs_next  = mpls_off;
                        if (recent_next[8])
                        begin
                            if ({1'b0, mpls_off} + 16'd20 >= len_ext)
                            begin
                                emit       = 1'b1;
                                em_status  = ST_MPLS_NO_IP;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_IPV;
                            end
                        end
                        else if ({1'b0, mpls_off} + 16'd4 >= len_ext)
                        begin
                            emit       = 1'b1;
                            em_status  = ST_TRUNC_LINK;
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_IPV:
                begin
                    if (rel == '0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_DONE;
                        if (ev_data.data_byte[7:4] == 4'd4 || ev_data.data_byte[7:4] == 4'd6)
                        begin
                            em_kind  = (ev_data.data_byte[7:4] == 4'd4) ? L3_IPV4 : L3_IPV6;
                            em_proto = proto_next;
                            em_off   = hs_next;
                        end
                        else
                        begin
                            em_status = ST_MPLS_NO_IP;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Select the next header from the protocol just read
        if (disp)
        begin
            proto_next = disp_proto;
            hs_next    = disp_off;
            if (disp_proto == ETYPE_VLAN_Q || disp_proto == ETYPE_VLAN_AD
                || disp_proto == ETYPE_MPLS)
            begin
                if (disp_proto == ETYPE_MPLS)
                    mpls_next = 1'b1;
                if ({1'b0, disp_off} + 16'd4 >= len_ext)
                begin
                    emit       = 1'b1;
                    em_status  = ST_TRUNC_LINK;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = (disp_proto == ETYPE_MPLS) ? PH_MPLS : PH_VLAN;
                end
            end
            else if (disp_proto == ETYPE_PPPOE)
            begin
                if ({1'b0, disp_off} + 16'd8 >= len_ext)
                begin
                    emit       = 1'b1;
                    em_status  = ST_TRUNC_LINK;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = PH_PPPOE;
                end
            end
            else
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
                if (disp_proto == ETYPE_IPV4 || disp_proto == ETYPE_IPV6
                    || disp_proto == ETYPE_ARP || disp_proto == ETYPE_RARP)
                begin
                    if (disp_proto == ETYPE_IPV4)
                        em_kind = L3_IPV4;
                    else if (disp_proto == ETYPE_IPV6)
                        em_kind = L3_IPV6;
                    else
                        em_kind = L3_ARP;
                    em_proto = disp_proto;
                    em_off   = disp_off;
                end
                else
                begin
                    em_status = ST_ETH_NON_IP;
                end
            end
        end

        // Frame ended before any decision
        if (ev_data.last && !sent_next && !emit)
        begin
            emit       = 1'b1;
            em_status  = ST_TRUNC_LINK;
            em_kind    = L3_NONE;
            em_proto   = '0;
            em_off     = '0;
            phase_next = PH_DONE;
        end
        if (emit)
            sent_next = 1'b1;

        res_data_next.status          = em_status;
        res_data_next.l3_kind         = em_kind;
        res_data_next.ether_type      = etype_next;
        res_data_next.next_protocol   = em_proto;
        res_data_next.outer_vlan      = ovlan_next;
        res_data_next.inner_vid       = ivlan_next;
        res_data_next.outer_vlan_seen = vflags_next[0];
        res_data_next.inner_vlan_seen = vflags_next[1];
        res_data_next.mpls_seen       = mpls_next;
        res_data_next.l2_offset       = prefix_next ? 5'(PREFIX_BYTES) : 5'd0;
        res_data_next.l3_offset       = em_off;

        res_valid_next = res_valid_reg;
        if (fire && emit)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hs_reg     <= hs_next;
            recent_reg <= recent_next;
            len_reg    <= len_next;
            proto_reg  <= proto_next;
            etype_reg  <= etype_next;
            ovlan_reg  <= ovlan_next;
            ivlan_reg  <= ivlan_next;
            vflags_reg <= vflags_next;
            mpls_reg   <= mpls_next;
            prefix_reg <= prefix_next;
        end
        if (fire && emit)
            res_data_reg <= res_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DONE;
            sent_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                sent_reg  <= sent_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

FILE: rtl/l2_encapsulation_header_parser_core.sv
// Channel   Direction  Handshake                 Payload
// byte      in         byte_valid / byte_ready   byte_data  (byte_item_t)
// res       out        res_valid  / res_ready    res_data   (result_item_t)
//
// One byte transfer per cycle sustained while results are taken; the byte that
// decides a result passes through the byte queue, then the result is held in the result register.
// The back parser takes one byte per cycle and is held only by a full result register.
// Reset clears frame tracking, the queue and the result register; the next byte
// is treated as the first of a frame.
// A stalled result stalls the back parser; the 4-entry queue keeps byte_ready
// high until it holds four entries; then the front stalls too.
module l2_encapsulation_header_parser_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_ready,
    input  l2ehp_pkg::byte_item_t   byte_data,
    output logic                    res_valid,
    input  logic                    res_ready,
    output l2ehp_pkg::result_item_t res_data
);
    import l2ehp_pkg::*;

    // Front to queue
    logic        fr_valid;
    logic        fr_ready;
    byte_event_t fr_data;

    // Queue to back
    logic        bk_valid;
    logic        bk_ready;
    byte_event_t bk_data;

    // Front: count bytes, mark frame start, clamp the length
    l2ehp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .ev_valid   (fr_valid),
        .ev_ready   (fr_ready),
        .ev_data    (fr_data)
    );

    // Queue: absorb short stalls of the back parser
    l2ehp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_data),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_data)
    );

    // Back: walk headers and hold the single result of each frame
    l2ehp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (bk_valid),
        .ev_ready  (bk_ready),
        .ev_data   (bk_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

FILE: rtl/l2ehp_checker.sv
module l2ehp_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    res_valid,
    input logic                    res_ready,
    input l2ehp_pkg::result_item_t res_data
);
    import l2ehp_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result dropped or changed while stalled");

    a_ok_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.status == ST_OK) == (res_data.l3_kind != L3_NONE)))
        else $error("status and layer-3 kind disagree");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status != ST_OK
        |-> res_data.l3_offset == '0 && res_data.next_protocol == '0)
        else $error("failed result carries layer-3 fields");

    a_vlan_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.inner_vlan_seen |-> res_data.outer_vlan_seen)
        else $error("inner tag without outer tag");

    a_prefix_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status == ST_TRUNC_PREFIX |-> res_data.l2_offset == '0)
        else $error("prefix offset set on truncated prefix");

endmodule

bind l2_encapsulation_header_parser_core l2ehp_checker u_l2ehp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
);

FILE: tb/sv/tb_l2_encapsulation_header_parser_core.sv
`timescale 1ns / 100ps

module tb_l2_encapsulation_header_parser_core;

    import l2ehp_pkg::*;

    // Header sizes and field positions used by the frame tracker
    localparam int unsigned VLAN_TAG_BYTES   = 4;
    localparam int unsigned PPPOE_HDR_BYTES  = 8;
    localparam int unsigned MPLS_LABEL_BYTES = 4;
    localparam int unsigned IPV4_MIN_BYTES   = 20;
    localparam int unsigned TCI_END          = 1;
    localparam int unsigned POS_MAX          = 32767;
    localparam int unsigned LENGTH_FIELD_MAX = 32767;
    localparam logic [3:0]  IP_VERSION_4     = 4'd4;
    localparam logic [3:0]  IP_VERSION_6     = 4'd6;

    typedef enum logic [3:0] {
        PH_START,
        PH_ETH0,
        PH_ETH1,
        PH_VLAN,
        PH_PPPOE,
        PH_MPLS,
        PH_IPV,
        PH_DONE
    } frame_phase_e;

    logic         clk;
    logic         rst_n;
    logic         byte_valid;
    logic         byte_ready;
    byte_item_t   byte_data;
    logic         res_valid;
    logic         res_ready;
    result_item_t res_data;

    l2_encapsulation_header_parser_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    // Parse verdicts predicted for frames whose deciding byte has been
    // transferred, oldest first.
    result_item_t awaited_verdicts[$];
    int unsigned  failures = 0;

    // Bytes of the frame being assembled by the current test.
    logic [7:0]   frame_bytes[$];

    // Sender pacing: bursts of random length, optionally with idle gaps.
    int unsigned  burst_left   = 0;
    bit           gaps_enabled = 1'b1;

    // ------------------------------------------------------------------
    // Frame tracker state, mirrors what the parser keeps per frame
    // ------------------------------------------------------------------
    frame_phase_e phase_q    = PH_START;
    int unsigned  pos_q      = 0;
    int unsigned  hdr_q      = 0;
    int unsigned  len_q      = 0;
    logic [15:0]  recent_q   = '0;
    logic [15:0]  proto_q    = '0;
    logic [15:0]  etype_q    = '0;
    logic [11:0]  ovlan_q    = '0;
    logic [11:0]  ivlan_q    = '0;
    logic [1:0]   vlan_flags = '0;
    logic         mpls_q     = 1'b0;
    logic         prefix_q   = 1'b0;
    logic         decided_q  = 1'b0;

    // Clock and watchdog
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Slowest legal run is well under a millisecond; this leaves ample margin.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------

    // Record the frame's verdict with the fields gathered so far and close
    // the frame: later bytes up to the last one are consumed silently.
    function automatic void record_verdict(logic [2:0] st, logic [1:0] kind,
                                           logic [15:0] proto, int unsigned l3off);
        result_item_t r;
        r.status          = st;
        r.l3_kind         = kind;
        r.ether_type      = etype_q;
        r.next_protocol   = proto;
        r.outer_vlan      = ovlan_q;
        r.inner_vid       = ivlan_q;
        r.outer_vlan_seen = vlan_flags[0];
        r.inner_vlan_seen = vlan_flags[1];
        r.mpls_seen       = mpls_q;
        r.l2_offset       = prefix_q ? 5'(PREFIX_BYTES) : 5'd0;
        r.l3_offset       = l3off[14:0];
        awaited_verdicts.push_back(r);
        phase_q   = PH_DONE;
        decided_q = 1'b1;
    endfunction

    // Failures carry no layer-3 kind, protocol or offset.
    function automatic void record_failure(logic [2:0] st);
        record_verdict(st, L3_NONE, 16'h0000, 0);
    endfunction

    // Pick the header that starts at offset d. Each VLAN, PPPoE or MPLS header is
    // taken only when it ends strictly before the stated length.
    function automatic void open_header(logic [15:0] proto, int unsigned d);
        proto_q = proto;
        hdr_q   = d;
        if (proto == ETYPE_VLAN_Q || proto == ETYPE_VLAN_AD)
        begin
            if (d + VLAN_TAG_BYTES >= len_q) record_failure(ST_TRUNC_LINK);
            else phase_q = PH_VLAN;
        end
        else if (proto == ETYPE_PPPOE)
        begin
            if (d + PPPOE_HDR_BYTES >= len_q) record_failure(ST_TRUNC_LINK);
            else phase_q = PH_PPPOE;
        end
        else if (proto == ETYPE_MPLS)
        begin
            mpls_q = 1'b1;
            if (d + MPLS_LABEL_BYTES >= len_q) record_failure(ST_TRUNC_LINK);
            else phase_q = PH_MPLS;
        end
        else if (proto == ETYPE_IPV4)
            record_verdict(ST_OK, L3_IPV4, proto, d);
        else if (proto == ETYPE_IPV6)
            record_verdict(ST_OK, L3_IPV6, proto, d);
        else if (proto == ETYPE_ARP || proto == ETYPE_RARP)
            record_verdict(ST_OK, L3_ARP, proto, d);
        else
            record_failure(ST_ETH_NON_IP);
    endfunction

    // Advance the frame tracker by one transferred byte.
    function automatic void track_frame_byte(byte_item_t item);
        int unsigned rel;
        int unsigned d;
        if (phase_q == PH_START)
        begin
            pos_q      = 0;
            hdr_q      = 0;
            recent_q   = '0;
            proto_q    = '0;
            etype_q    = '0;
            ovlan_q    = '0;
            ivlan_q    = '0;
            vlan_flags = '0;
            mpls_q     = 1'b0;
            prefix_q   = 1'b0;
            decided_q  = 1'b0;
            len_q      = (item.frame_length > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES
                                                               : item.frame_length;
            phase_q    = PH_ETH0;
            if (len_q < ETH_HDR_BYTES) record_failure(ST_TRUNC_LINK);
        end

        if (phase_q != PH_DONE)
        begin
            recent_q = {recent_q[7:0], item.data_byte};
            // Wraps to a huge value before the header starts, as intended.
            rel = pos_q - hdr_q;
            case (phase_q)
                PH_ETH0:
                begin
                    if (rel == ETH_HDR_BYTES - 1)
                    begin
                        etype_q = recent_q;
                        if (recent_q == ETYPE_PREFIX)
                        begin
                            if (PREFIX_BYTES + ETH_HDR_BYTES >= len_q)
                                record_failure(ST_TRUNC_PREFIX);
                            else
                            begin
                                prefix_q = 1'b1;
                                hdr_q    = PREFIX_BYTES;
                                phase_q  = PH_ETH1;
                            end
                        end
                        else
                            open_header(recent_q, ETH_HDR_BYTES);
                    end
                end
                PH_ETH1:
                begin
                    if (rel == ETH_HDR_BYTES - 1)
                    begin
                        etype_q = recent_q;
                        open_header(recent_q, hdr_q + ETH_HDR_BYTES);
                    end
                end
                PH_VLAN:
                begin
                    if (rel == TCI_END)
                    begin
                        if (vlan_flags[0])
                        begin
                            ivlan_q       = recent_q[11:0];
                            vlan_flags[1] = 1'b1;
                        end
                        else
                        begin
                            ovlan_q       = recent_q[11:0];
                            vlan_flags[0] = 1'b1;
                        end
                    end
                    else if (rel == VLAN_TAG_BYTES - 1)
                    begin
                        etype_q = recent_q;
                        open_header(recent_q, hdr_q + VLAN_TAG_BYTES);
                    end
                end
                PH_PPPOE:
                begin
                    if (rel == PPPOE_HDR_BYTES - 1)
                    begin
                        d = hdr_q + PPPOE_HDR_BYTES;
                        if (recent_q == PPP_IPV4)
                            record_verdict(ST_OK, L3_IPV4, recent_q, d);
                        else if (recent_q == PPP_IPV6)
                            record_verdict(ST_OK, L3_IPV6, recent_q, d);
                        else
                            record_failure(ST_PPPOE_NON_IP);
                    end
                end
                PH_MPLS:
                begin
                    if (rel == MPLS_LABEL_BYTES - 1)
                    begin
                        d     = hdr_q + MPLS_LABEL_BYTES;
                        hdr_q = d;
                        // Bottom-of-stack bit is bit 0 of the label's third byte.
                        if (recent_q[8])
                        begin
                            if (d + IPV4_MIN_BYTES >= len_q) record_failure(ST_MPLS_NO_IP);
                            else phase_q = PH_IPV;
                        end
                        else if (d + MPLS_LABEL_BYTES >= len_q)
                            record_failure(ST_TRUNC_LINK);
                    end
                end
                PH_IPV:
                begin
                    if (rel == 0)
                    begin
                        if (item.data_byte[7:4] == IP_VERSION_4)
                            record_verdict(ST_OK, L3_IPV4, proto_q, hdr_q);
                        else if (item.data_byte[7:4] == IP_VERSION_6)
                            record_verdict(ST_OK, L3_IPV6, proto_q, hdr_q);
                        else
                            record_failure(ST_MPLS_NO_IP);
                    end
                end
                default: ;
            endcase
        end

        // A frame that ends undecided is reported as truncated.
        if (item.last_byte && !decided_q) record_failure(ST_TRUNC_LINK);

        if (item.last_byte)
        begin
            phase_q = PH_START;
            pos_q   = 0;
        end
        else if (pos_q < POS_MAX)
            pos_q++;
    endfunction

    // ------------------------------------------------------------------
    // Result side: check every transfer, stall on a pattern of its own
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    initial
    begin : result_checker
        result_item_t want;
        int unsigned  cyc;
        int unsigned  stall_mode;
        logic [7:0]   stall_mask;
        cyc        = 0;
        stall_mode = 0;
        stall_mask = 8'hff;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            // Sample before this edge's updates land: values are the ones
            // the block saw at the edge.
            if (res_valid && res_ready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    $error("result transfer with no verdict outstanding");
                    failures++;
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    check_field("status", 16'(want.status), 16'(res_data.status));
                    check_field("l3_kind", 16'(want.l3_kind), 16'(res_data.l3_kind));
                    check_field("ether_type", want.ether_type, res_data.ether_type);
                    check_field("next_protocol", want.next_protocol,
                                res_data.next_protocol);
                    check_field("outer_vlan", 16'(want.outer_vlan),
                                16'(res_data.outer_vlan));
                    check_field("inner_vid", 16'(want.inner_vid),
                                16'(res_data.inner_vid));
                    check_field("outer_vlan_seen", 16'(want.outer_vlan_seen),
                                16'(res_data.outer_vlan_seen));
                    check_field("inner_vlan_seen", 16'(want.inner_vlan_seen),
                                16'(res_data.inner_vlan_seen));
                    check_field("mpls_seen", 16'(want.mpls_seen),
                                16'(res_data.mpls_seen));
                    check_field("l2_offset", 16'(want.l2_offset),
                                16'(res_data.l2_offset));
                    check_field("l3_offset", 16'(want.l3_offset),
                                16'(res_data.l3_offset));
                end
            end
            // Stall styles, switched from time to time: always ready, a rotating
            // mask, coin flips, or a long hold that backs up the byte queue.
            if (cyc % 48 == 0)
            begin
                stall_mode = $urandom_range(3);
                stall_mask = 8'($urandom);
            end
            case (stall_mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= stall_mask[cyc % 8];
                2:       res_ready <= 1'($urandom_range(1));
                default: res_ready <= (cyc % 12 == 0);
            endcase
            cyc++;
        end
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // Transfer one byte. Valid stays up across a burst; gaps drop it.
    task automatic send_byte(input byte_item_t item);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_enabled && $urandom_range(3) != 0)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        byte_data  <= item;
        do @(posedge clk); while (!byte_ready);
        track_frame_byte(item);
    endtask

    // Hold the sender until every outstanding verdict has been transferred.
    task automatic wait_for_verdicts();
        byte_valid <= 1'b0;
        burst_left = 0;
        while (awaited_verdicts.size() != 0) @(posedge clk);
    endtask

    // Send the assembled frame; only its first byte carries the real length.
    task automatic send_frame(input int unsigned stated);
        byte_item_t item;
        foreach (frame_bytes[i])
        begin
            item.data_byte    = frame_bytes[i];
            item.frame_length = (i == 0) ? stated[14:0] : 15'($urandom);
            item.last_byte    = (i == frame_bytes.size() - 1);
            send_byte(item);
        end
    endtask

    task automatic send_exact();
        send_frame(frame_bytes.size());
    endtask

    function automatic void add_byte(logic [7:0] v);
        frame_bytes.push_back(v);
    endfunction

    function automatic void add_word(logic [15:0] w);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endfunction

    function automatic void add_bytes(int unsigned n);
        repeat (n) add_byte(8'($urandom));
    endfunction

    function automatic void add_mpls_label(logic bos);
        add_bytes(2);
        add_byte({7'($urandom), bos});
        add_bytes(1);
    endfunction

    // Start a new frame: two random MAC addresses and the given ethertype.
    function automatic void begin_frame(logic [15:0] etype);
        frame_bytes.delete();
        add_bytes(12);
        add_word(etype);
    endfunction

    function automatic logic [15:0] random_other_etype();
        logic [15:0] v;
        do
            v = 16'($urandom);
        while (v == ETYPE_VLAN_Q || v == ETYPE_VLAN_AD || v == ETYPE_PPPOE ||
               v == ETYPE_MPLS || v == ETYPE_IPV4 || v == ETYPE_IPV6 ||
               v == ETYPE_ARP || v == ETYPE_RARP || v == ETYPE_PREFIX);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Lengths below the Ethernet header fail on the first byte.
    task automatic test_short_frames();
        frame_bytes.delete();
        add_bytes(1);
        send_frame(1);
        frame_bytes.delete();
        add_bytes(13);
        send_exact();
        frame_bytes.delete();
        add_bytes(1);
        send_frame(0);
    endtask

    task automatic test_plain_ethertypes();
        logic [15:0] kinds[5];
        kinds[0] = ETYPE_IPV4;
        kinds[1] = ETYPE_IPV6;
        kinds[2] = ETYPE_ARP;
        kinds[3] = ETYPE_RARP;
        kinds[4] = random_other_etype();
        foreach (kinds[k])
        begin
            begin_frame(kinds[k]);
            add_bytes(4);
            send_exact();
        end
        // Header exactly fills the frame.
        begin_frame(ETYPE_IPV4);
        send_exact();
    endtask

    task automatic test_vlan_stacks();
        for (int n = 1; n <= 3; n++)
        begin
            begin_frame(ETYPE_VLAN_Q);
            for (int t = 0; t < n; t++)
            begin
                add_word(16'($urandom));
                add_word((t == n - 1) ? ETYPE_IPV6 : ETYPE_VLAN_AD);
            end
            add_bytes(4);
            send_exact();
        end
        // VLAN id extremes, then a non-IP ethertype behind two tags.
        begin_frame(ETYPE_VLAN_AD);
        add_word(16'hffff);
        add_word(ETYPE_VLAN_Q);
        add_word(16'h0000);
        add_word(random_other_etype());
        add_bytes(4);
        send_exact();
        // Tag does not fit in the stated length.
        begin_frame(ETYPE_VLAN_Q);
        add_bytes(4);
        send_exact();
    endtask

    task automatic test_fabric_prefix();
        begin_frame(ETYPE_PREFIX);
        add_bytes(2);
        add_bytes(12);
        add_word(ETYPE_IPV4);
        add_bytes(20);
        send_exact();
        begin_frame(ETYPE_PREFIX);
        add_bytes(14);
        add_word(ETYPE_VLAN_Q);
        add_word(16'($urandom));
        add_word(ETYPE_ARP);
        add_bytes(8);
        send_exact();
        // Prefix plus header does not fit.
        begin_frame(ETYPE_PREFIX);
        add_bytes(16);
        send_exact();
    endtask

    task automatic test_pppoe();
        logic [15:0] ppp[3];
        ppp[0] = PPP_IPV4;
        ppp[1] = PPP_IPV6;
        ppp[2] = 16'hc021;
        foreach (ppp[k])
        begin
            begin_frame(ETYPE_PPPOE);
            add_bytes(6);
            add_word(ppp[k]);
            add_bytes(4);
            send_exact();
        end
        begin_frame(ETYPE_PPPOE);
        add_bytes(8);
        send_exact();
    endtask

    task automatic test_mpls();
        begin_frame(ETYPE_MPLS);
        add_mpls_label(1'b1);
        add_byte({IP_VERSION_4, 4'h5});
        add_bytes(29);
        send_exact();
        begin_frame(ETYPE_MPLS);
        add_mpls_label(1'b0);
        add_mpls_label(1'b1);
        add_byte({IP_VERSION_6, 4'h0});
        add_bytes(39);
        send_exact();
        // Neither IPv4 nor IPv6 after the stack.
        begin_frame(ETYPE_MPLS);
        add_mpls_label(1'b1);
        add_byte(8'h0f);
        add_bytes(29);
        send_exact();
        // Bottom of stack reached but no room for an IP header.
        begin_frame(ETYPE_MPLS);
        add_mpls_label(1'b1);
        add_bytes(20);
        send_exact();
        // Another label announced but it does not fit.
        begin_frame(ETYPE_MPLS);
        add_mpls_label(1'b0);
        add_bytes(4);
        send_exact();
        // First label does not fit.
        begin_frame(ETYPE_MPLS);
        add_bytes(4);
        send_exact();
    endtask

    // Last byte arrives before any decision.
    task automatic test_early_end();
        frame_bytes.delete();
        add_bytes(6);
        send_frame(60);
        begin_frame(ETYPE_VLAN_Q);
        add_bytes(2);
        send_frame(64);
    endtask

    task automatic test_length_extremes();
        begin_frame(ETYPE_IPV4);
        add_bytes(20);
        send_frame(LENGTH_FIELD_MAX);
        begin_frame(ETYPE_PPPOE);
        add_bytes(6);
        add_word(PPP_IPV6);
        send_frame(MAX_FRAME_BYTES);
        begin_frame(ETYPE_MPLS);
        add_mpls_label(1'b1);
        add_byte({IP_VERSION_4, 4'h5});
        send_frame(MAX_FRAME_BYTES + 1);
        // Bytes past the stated length, decided well before them.
        begin_frame(ETYPE_IPV4);
        add_bytes(26);
        send_frame(20);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed encapsulations, some noise
    // ------------------------------------------------------------------
    function automatic void build_random_frame();
        int unsigned tags;
        int unsigned labels;
        logic        no_bos;
        logic [3:0]  version;
        frame_bytes.delete();
        if ($urandom_range(9) == 0)
        begin
            begin_frame(ETYPE_PREFIX);
            add_bytes(2);
        end
        add_bytes(12);
        tags = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (tags)
        begin
            add_word($urandom_range(1) ? ETYPE_VLAN_Q : ETYPE_VLAN_AD);
            add_word(16'($urandom));
        end
        case ($urandom_range(9))
            0, 1: add_word(ETYPE_IPV4);
            2:    add_word(ETYPE_IPV6);
            3:    add_word($urandom_range(1) ? ETYPE_ARP : ETYPE_RARP);
            4:
            begin
                add_word(ETYPE_PPPOE);
                add_bytes(6);
                case ($urandom_range(2))
                    0:       add_word(PPP_IPV4);
                    1:       add_word(PPP_IPV6);
                    default: add_word(16'($urandom));
                endcase
            end
            5, 6:
            begin
                add_word(ETYPE_MPLS);
                labels = $urandom_range(1, 3);
                no_bos = ($urandom_range(5) == 0);
                for (int i = 0; i < labels; i++)
                    add_mpls_label(!no_bos && (i == labels - 1));
                case ($urandom_range(3))
                    0:       version = 4'($urandom);
                    1:       version = IP_VERSION_6;
                    default: version = IP_VERSION_4;
                endcase
                add_byte({version, 4'($urandom)});
            end
            7:    add_word(random_other_etype());
            8:    add_word(16'($urandom));
            default:
            begin
                // Pure noise frame.
                frame_bytes.delete();
                add_bytes($urandom_range(1, 40));
            end
        endcase
        add_bytes($urandom_range(0, 30));
    endfunction

    task automatic test_random_traffic();
        int unsigned bytes_sent;
        int unsigned frames;
        int unsigned stated;
        int unsigned cut;
        bytes_sent = 0;
        frames     = 0;
        while (bytes_sent < 150 || frames < 4)
        begin
            if (frames % 16 == 0) gaps_enabled = ($urandom_range(3) != 0);
            build_random_frame();
            stated = frame_bytes.size();
            case ($urandom_range(7))
                0: stated = $urandom_range(0, stated);
                1: stated = $urandom_range(stated, LENGTH_FIELD_MAX);
                2:
                begin
                    cut = $urandom_range(1, frame_bytes.size());
                    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                end
                default: ;
            endcase
            bytes_sent += frame_bytes.size();
            send_frame(stated);
            frames++;
            if (frames % 25 == 0) wait_for_verdicts();
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_plain_ethertypes();
        test_vlan_stacks();
        test_fabric_prefix();
        test_pppoe();
        test_mpls();
        test_early_end();
        // Let the pipeline drain completely once before the long frames.
        wait_for_verdicts();
        test_length_extremes();
        test_random_traffic();

        // Drain, then watch a little longer for stray result transfers.
        wait_for_verdicts();
        repeat (16) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
